FILE: sv/lsp_pkg.sv
// Shared constants and controller/datapath interface types for the latency sample packer.
`default_nettype none
package lsp_pkg;

    // Default geometry of the row register and row store.
    localparam int LANES_DEF = 16;
    localparam int ROWS_DEF  = 64;

    // Fixed field widths.
    localparam int TS_W      = 40;
    localparam int CNT_W     = 40;
    localparam int LAT_W     = 32;
    localparam int ADDR_W    = 32;
    localparam int OUT_LANES = 16;
    localparam int BITS_W    = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pkt_write;    // Take a packet: update lane register and row store.
        logic start_flush;  // Begin a full-store flush from row zero.
        logic start_end;    // Begin an end-of-test flush of the occupied rows.
        logic rd_en;        // Read the current row from the row store.
        logic load_row;     // Load the read row into the output word register.
        logic load_empty;   // Load the empty end-of-test report word.
        logic rd_next;      // Advance to the next row to read.
        logic end_clear;    // Return counters and lane register to reset values.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush_due;    // The next packet completes a full store.
        logic occ_zero;     // No row is occupied.
        logic out_last;     // The word in the output register is the last of its run.
    } status_t;

endpackage
`default_nettype wire

FILE: sv/lsp_datapath.sv
// Datapath of the latency sample packer: counters, lane register, row store and output word.
`default_nettype none
module lsp_datapath #(
    parameter int LANES = lsp_pkg::LANES_DEF,
    parameter int ROWS  = lsp_pkg::ROWS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [lsp_pkg::TS_W-1:0]     send_time,
    input  wire logic [lsp_pkg::TS_W-1:0]     recv_time,
    input  wire lsp_pkg::cmd_t                cmd,
    output      lsp_pkg::status_t             status,
    output      logic [lsp_pkg::ADDR_W-1:0]   row_address,
    output      logic                         write_valid,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_0,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_1,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_2,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_3,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_4,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_5,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_6,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_7,
    output      logic [lsp_pkg::CNT_W-1:0]    packets_seen,
    output      logic                         run_last
);

    localparam int LAW   = $clog2(LANES);
    localparam int RAW   = $clog2(ROWS);
    localparam int ROW_W = LANES * lsp_pkg::LAT_W;
    localparam int PAD_W = lsp_pkg::OUT_LANES * lsp_pkg::LAT_W;

    // Control state.
    logic [lsp_pkg::CNT_W-1:0]  count_reg;
    logic [lsp_pkg::ADDR_W-1:0] offset_reg;
    logic [LAW-1:0]             lane_idx_reg;
    logic [RAW-1:0]             row_idx_reg;
    logic [RAW-1:0]             rd_row_reg;
    logic [RAW-1:0]             last_row_reg;
    logic [ROW_W-1:0]           lane_reg;

    // Row store and its registered read port.
    logic [ROW_W-1:0]           row_mem [ROWS];
    logic [ROW_W-1:0]           rd_data_reg;

    // Output word register.
    logic [lsp_pkg::ADDR_W-1:0] out_addr_reg;
    logic                       out_wv_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [lsp_pkg::CNT_W-1:0]  out_seen_reg;
    logic                       out_last_reg;

    logic [lsp_pkg::LAT_W-1:0]  latency;
    logic [ROW_W-1:0]           row_next;
    logic                       lane_wrap;
    logic                       row_wrap;
    logic                       rd_last;
    logic [PAD_W-1:0]           padded;

    // Latency sample and the row with the new sample placed in its lane.
    always_comb
    begin
        latency = recv_time[lsp_pkg::LAT_W-1:0] - send_time[lsp_pkg::LAT_W-1:0];
        for (int l = 0; l < LANES; l++)
        begin
            if (lane_idx_reg == LAW'(l))
                row_next[l*lsp_pkg::LAT_W +: lsp_pkg::LAT_W] = latency;
            else
                row_next[l*lsp_pkg::LAT_W +: lsp_pkg::LAT_W] =
                    lane_reg[l*lsp_pkg::LAT_W +: lsp_pkg::LAT_W];
        end
    end

    assign lane_wrap = (lane_idx_reg == LAW'(LANES - 1));
    assign row_wrap  = (row_idx_reg == RAW'(ROWS - 1));
    assign rd_last   = (rd_row_reg == last_row_reg);

    // Status toward the controller.
    assign status.flush_due = lane_wrap && row_wrap;
    assign status.occ_zero  = (lane_idx_reg == '0) && (row_idx_reg == '0);
    assign status.out_last  = out_last_reg;

    // Counters, lane register and read pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            offset_reg   <= '0;
            lane_idx_reg <= '0;
            row_idx_reg  <= '0;
            rd_row_reg   <= '0;
            last_row_reg <= '0;
            lane_reg     <= '0;
        end
        else
        begin
            if (cmd.pkt_write)
            begin
                lane_reg  <= row_next;
                count_reg <= count_reg + 1'b1;
                if (lane_wrap)
                begin
                    lane_idx_reg <= '0;
                    row_idx_reg  <= row_wrap ? '0 : row_idx_reg + 1'b1;
                end
                else
                begin
                    lane_idx_reg <= lane_idx_reg + 1'b1;
                end
            end
            if (cmd.start_flush)
            begin
                rd_row_reg   <= '0;
                last_row_reg <= RAW'(ROWS - 1);
            end
            if (cmd.start_end)
            begin
                // Occupied rows run up to the current row if it holds samples.
                rd_row_reg   <= '0;
                last_row_reg <= (lane_idx_reg != '0) ? row_idx_reg : row_idx_reg - 1'b1;
            end
            if (cmd.rd_next)
                rd_row_reg <= rd_row_reg + 1'b1;
            if (cmd.load_row)
                offset_reg <= offset_reg + 1'b1;
            if (cmd.end_clear)
            begin
                count_reg    <= '0;
                offset_reg   <= '0;
                lane_idx_reg <= '0;
                row_idx_reg  <= '0;
                lane_reg     <= '0;
            end
        end
    end

    // Row store: one row written per packet, one row read per flush step.
    always_ff @(posedge clk)
    begin
        if (cmd.pkt_write)
            row_mem[row_idx_reg] <= row_next;
        if (cmd.rd_en)
            rd_data_reg <= row_mem[rd_row_reg];
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            out_addr_reg <= offset_reg;
            out_wv_reg   <= 1'b1;
            out_row_reg  <= rd_data_reg;
            out_seen_reg <= count_reg;
            out_last_reg <= rd_last;
        end
        else if (cmd.load_empty)
        begin
            out_addr_reg <= '0;
            out_wv_reg   <= 1'b0;
            out_row_reg  <= '0;
            out_seen_reg <= count_reg;
            out_last_reg <= 1'b1;
        end
    end

    // Spread the lanes over the sixteen output lane slots, zero beyond LANES.
    for (genvar k = 0; k < lsp_pkg::OUT_LANES; k++)
    begin : g_pad
        if (k < LANES)
        begin : g_used
            assign padded[k*lsp_pkg::LAT_W +: lsp_pkg::LAT_W] =
                out_row_reg[k*lsp_pkg::LAT_W +: lsp_pkg::LAT_W];
        end
        else
        begin : g_zero
            assign padded[k*lsp_pkg::LAT_W +: lsp_pkg::LAT_W] = '0;
        end
    end

    assign row_address  = out_addr_reg;
    assign write_valid  = out_wv_reg;
    assign packets_seen = out_seen_reg;
    assign run_last     = out_last_reg;
    assign row_bits_0   = padded[0*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];
    assign row_bits_1   = padded[1*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];
    assign row_bits_2   = padded[2*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];
    assign row_bits_3   = padded[3*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];
    assign row_bits_4   = padded[4*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];
    assign row_bits_5   = padded[5*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];
    assign row_bits_6   = padded[6*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];
    assign row_bits_7   = padded[7*lsp_pkg::BITS_W +: lsp_pkg::BITS_W];

endmodule
`default_nettype wire

FILE: sv/lsp_ctrl.sv
// Controller state machine of the latency sample packer: intake, flush sequencing, output word.
`default_nettype none
module lsp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pkt_valid,
    output      logic             pkt_ready,
    input  wire logic             end_of_test,
    output      logic             res_valid,
    input  wire logic             res_ready,
    input  wire lsp_pkg::status_t status,
    output      lsp_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   end_mode_reg;
    logic   end_mode_next;
    logic   accept;

    assign pkt_ready = (state_reg == ST_IDLE);
    assign res_valid = out_valid_reg;
    assign accept    = pkt_valid && pkt_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        end_mode_next  = end_mode_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (end_of_test)
                    begin
                        end_mode_next = 1'b1;
                        if (status.occ_zero)
                        begin
                            cmd.load_empty = 1'b1;
                            out_valid_next = 1'b1;
                            state_next     = ST_HOLD;
                        end
                        else
                        begin
                            cmd.start_end = 1'b1;
                            state_next    = ST_READ;
                        end
                    end
                    else
                    begin
                        cmd.pkt_write = 1'b1;
                        if (status.flush_due)
                        begin
                            end_mode_next   = 1'b0;
                            cmd.start_flush = 1'b1;
                            state_next      = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_row   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (res_ready)
                begin
                    out_valid_next = 1'b0;
                    if (status.out_last)
                    begin
                        cmd.end_clear = end_mode_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            end_mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            end_mode_reg  <= end_mode_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/latency_sample_packer.sv
// Top level of the latency sample packer: controller and datapath.
//
// Channel   Signals                          Moves
// pkt       pkt_valid / pkt_ready            one packet word (timestamps, end mark)
// res       res_valid / res_ready            one result word (row write or report)
//
// A packet that neither completes a store nor ends the test leaves intake open; the next may
// follow directly. A flush reads the row store one row at a time, each row passing through
// the READ, LOAD and HOLD states; HOLD waits as long as res_ready stays low.
// Intake stays closed until the last word of a flush has been taken.
// Reset clears the counters and lane register; the row store is not cleared.
`default_nettype none
module latency_sample_packer #(
    parameter int LANES = lsp_pkg::LANES_DEF,
    parameter int ROWS  = lsp_pkg::ROWS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pkt_valid,
    output      logic                         pkt_ready,
    input  wire logic [lsp_pkg::TS_W-1:0]     packet_id,
    input  wire logic [lsp_pkg::TS_W-1:0]     send_time,
    input  wire logic [lsp_pkg::TS_W-1:0]     recv_time,
    input  wire logic                         end_of_test,
    output      logic                         res_valid,
    input  wire logic                         res_ready,
    output      logic [lsp_pkg::ADDR_W-1:0]   row_address,
    output      logic                         write_valid,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_0,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_1,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_2,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_3,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_4,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_5,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_6,
    output      logic [lsp_pkg::BITS_W-1:0]   row_bits_7,
    output      logic [lsp_pkg::CNT_W-1:0]    packets_seen,
    output      logic                         run_last
);

    lsp_pkg::cmd_t    cmd;
    lsp_pkg::status_t status;

    // The packet id carries no information for the results.
    logic unused_id;
    assign unused_id = ^packet_id;

    // Controller.
    lsp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_ready   (pkt_ready),
        .end_of_test (end_of_test),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath.
    lsp_datapath #(
        .LANES (LANES),
        .ROWS  (ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .send_time    (send_time),
        .recv_time    (recv_time),
        .cmd          (cmd),
        .status       (status),
        .row_address  (row_address),
        .write_valid  (write_valid),
        .row_bits_0   (row_bits_0),
        .row_bits_1   (row_bits_1),
        .row_bits_2   (row_bits_2),
        .row_bits_3   (row_bits_3),
        .row_bits_4   (row_bits_4),
        .row_bits_5   (row_bits_5),
        .row_bits_6   (row_bits_6),
        .row_bits_7   (row_bits_7),
        .packets_seen (packets_seen),
        .run_last     (run_last)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the latency sample packer: directed table, then random runs.
`timescale 1ns / 1ps
module tb;

    localparam int TS_W         = lsp_pkg::TS_W;
    localparam int CNT_W        = lsp_pkg::CNT_W;
    localparam int LAT_W        = lsp_pkg::LAT_W;
    localparam int ADDR_W       = lsp_pkg::ADDR_W;
    localparam int OUT_LANES    = lsp_pkg::OUT_LANES;
    localparam int BITS_W       = lsp_pkg::BITS_W;
    localparam int LANES        = lsp_pkg::LANES_DEF;
    localparam int ROWS         = lsp_pkg::ROWS_DEF;
    localparam int FULL_STORE   = LANES * ROWS;
    localparam int DIRECTED_N   = 24;
    localparam int RANDOM_ITEMS = 350;
    localparam int PACE_LEN     = 64;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 3 * ROWS + 16;

    // One packet word as the sender drives it; typed_in marks a row whose result is typed below.
    typedef struct packed {
        logic [TS_W-1:0] id;
        logic [TS_W-1:0] send_ts;
        logic [TS_W-1:0] recv_ts;
        logic            eot;
        logic            typed_in;
    } packet_t;

    // One result word, row bits ordered so that lane pair 7 sits at the top.
    typedef struct packed {
        logic [ADDR_W-1:0]                      row_address;
        logic                                   write_valid;
        logic [OUT_LANES/2-1:0][BITS_W-1:0]     row_bits;
        logic [CNT_W-1:0]                       packets_seen;
        logic                                   run_last;
    } result_word_t;

    // Idling phases of both channels.
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } pace_t;

    logic clk = 1'b0;
    logic rst_n;
    logic pkt_valid;
    logic pkt_ready;
    logic [TS_W-1:0] packet_id;
    logic [TS_W-1:0] send_time;
    logic [TS_W-1:0] recv_time;
    logic end_of_test;
    logic res_valid;
    logic res_ready;
    logic [ADDR_W-1:0] row_address;
    logic write_valid;
    logic [BITS_W-1:0] row_bits_0;
    logic [BITS_W-1:0] row_bits_1;
    logic [BITS_W-1:0] row_bits_2;
    logic [BITS_W-1:0] row_bits_3;
    logic [BITS_W-1:0] row_bits_4;
    logic [BITS_W-1:0] row_bits_5;
    logic [BITS_W-1:0] row_bits_6;
    logic [BITS_W-1:0] row_bits_7;
    logic [CNT_W-1:0] packets_seen;
    logic run_last;

    // Shadow state of the packer.
    logic [CNT_W-1:0]  packets_taken;
    logic [ADDR_W-1:0] next_address;
    logic [LAT_W-1:0]  lane_row [LANES];
    logic [LAT_W-1:0]  latency_rows [ROWS * LANES];

    result_word_t new_words [$];
    result_word_t expected_words [$];
    result_word_t typed_words [$];
    packet_t      directed [DIRECTED_N];

    pace_t pace = PACE_FULL;
    int    packets_pushed = 0;
    int    faults = 0;
    int    quiet_cycles = 0;

    latency_sample_packer i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int send_gap_pct();
        case (pace)
            PACE_SEND_GAPS: return 84;
            PACE_BOTH:      return 20;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (pace)
            PACE_RECV_STALLS: return 84;
            PACE_BOTH:        return 20;
            default:          return 0;
        endcase
    endfunction

    // Queue one row of the store as a memory write and advance the write offset.
    function automatic void emit_row(input int row, input logic [CNT_W-1:0] seen,
                                     input logic last);
        result_word_t w;
        int p;
        w = '0;
        w.row_address  = next_address;
        w.write_valid  = 1'b1;
        w.packets_seen = seen;
        w.run_last     = last;
        for (p = 0; p < OUT_LANES; p++)
        begin
            if (p < LANES)
                w.row_bits[p / 2][(p % 2) * 32 +: 32] = latency_rows[row * LANES + p];
        end
        new_words.push_back(w);
        next_address = next_address + 1'b1;
    endfunction

    // Work out the words that one accepted packet causes and update the shadow state.
    function automatic void predict_rows(input packet_t p);
        logic [TS_W-1:0] span;
        result_word_t report;
        int occupied;
        int lane;
        int row;
        int k;
        if (p.eot)
        begin
            occupied = int'((packets_taken / LANES) % ROWS)
                       + ((packets_taken % LANES != 0) ? 1 : 0);
            if (occupied == 0)
            begin
                // Nothing stored: a lone status word with no write.
                report = '0;
                report.packets_seen = packets_taken;
                report.run_last     = 1'b1;
                new_words.push_back(report);
            end
            else
            begin
                for (row = 0; row < occupied; row++)
                    emit_row(row, packets_taken, row == occupied - 1);
            end
            packets_taken = '0;
            next_address  = '0;
            for (k = 0; k < LANES; k++)
                lane_row[k] = '0;
        end
        else
        begin
            // Latency wraps at the timestamp width and keeps its low bits.
            span = p.recv_ts - p.send_ts;
            lane = int'(packets_taken % LANES);
            row  = int'((packets_taken / LANES) % ROWS);
            lane_row[lane] = span[LAT_W-1:0];
            for (k = 0; k < LANES; k++)
                latency_rows[row * LANES + k] = lane_row[k];
            packets_taken = packets_taken + 1'b1;
            if (packets_taken % FULL_STORE == 0)
            begin
                for (row = 0; row < ROWS; row++)
                    emit_row(row, packets_taken, row == ROWS - 1);
            end
        end
    endfunction

    function automatic packet_t random_packet(input logic eot);
        packet_t p;
        p = '0;
        p.id      = {8'($urandom), $urandom};
        p.send_ts = {8'($urandom), $urandom};
        p.eot     = eot;
        case ($urandom_range(0, 3))
            0:       p.recv_ts = {8'($urandom), $urandom};
            3:       p.recv_ts = p.send_ts - $urandom_range(1, 1000);
            default: p.recv_ts = p.send_ts + $urandom_range(0, 100000);
        endcase
        return p;
    endfunction

    // Drive one packet word, hold it until taken, then record what it should cause.
    task automatic push_packet(input packet_t p);
        int k;
        pace = pace_t'((packets_pushed / PACE_LEN) % 4);
        if ($urandom_range(0, 99) < send_gap_pct())
        begin
            pkt_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_gap_pct())
                @(posedge clk);
        end
        pkt_valid   <= 1'b1;
        packet_id   <= p.id;
        send_time   <= p.send_ts;
        recv_time   <= p.recv_ts;
        end_of_test <= p.eot;
        @(posedge clk);
        while (!pkt_ready)
            @(posedge clk);
        new_words.delete();
        predict_rows(p);
        if (p.typed_in)
        begin
            // The typed expectation stands in for the computed one.
            new_words.delete();
            new_words.push_back(typed_words.pop_front());
        end
        for (k = 0; k < new_words.size(); k++)
            expected_words.push_back(new_words[k]);
        packets_pushed++;
    endtask

    task automatic check_field(input string name, input logic [BITS_W-1:0] want,
                               input logic [BITS_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            faults++;
        end
    endtask

    // Result side: compare each taken word with the oldest expectation, then pick the next ready.
    always @(posedge clk)
    begin
        result_word_t got;
        result_word_t want;
        int p;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                got = {row_address, write_valid, row_bits_7, row_bits_6, row_bits_5,
                       row_bits_4, row_bits_3, row_bits_2, row_bits_1, row_bits_0,
                       packets_seen, run_last};
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word at address %h", row_address);
                    faults++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("row_address", BITS_W'(want.row_address),
                                BITS_W'(got.row_address));
                    check_field("write_valid", BITS_W'(want.write_valid),
                                BITS_W'(got.write_valid));
                    for (p = 0; p < OUT_LANES / 2; p++)
                        check_field($sformatf("row_bits_%0d", p), want.row_bits[p],
                                    got.row_bits[p]);
                    check_field("packets_seen", BITS_W'(want.packets_seen),
                                BITS_W'(got.packets_seen));
                    check_field("run_last", BITS_W'(want.run_last), BITS_W'(got.run_last));
                end
            end
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
        end
    end

    // Watchdog: too many cycles without a word taken on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (pkt_valid && pkt_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        result_word_t empty_report;
        result_word_t one_lane;
        int run_idx;
        int run_len;
        int short_total;
        int i;

        rst_n       <= 1'b0;
        pkt_valid   <= 1'b0;
        packet_id   <= '0;
        send_time   <= '0;
        recv_time   <= '0;
        end_of_test <= 1'b0;
        res_ready   <= 1'b0;

        packets_taken = '0;
        next_address  = '0;
        for (i = 0; i < LANES; i++)
            lane_row[i] = '0;

        // Results that can be read off directly.
        empty_report = '0;
        empty_report.run_last = 1'b1;
        one_lane = '0;
        one_lane.write_valid  = 1'b1;
        one_lane.row_bits[0]  = 64'h0000_0000_ffff_ffff;
        one_lane.packets_seen = 40'd1;
        one_lane.run_last     = 1'b1;
        typed_words.push_back(empty_report);
        typed_words.push_back(one_lane);
        typed_words.push_back(empty_report);

        directed = '{
            // End right after reset: status word only.
            '{40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0000, 1'b1, 1'b1},
            // Largest latency, then an end that writes that single lane.
            '{40'hff_ffff_ffff, 40'h00_0000_0000, 40'hff_ffff_ffff, 1'b0, 1'b0},
            '{40'h00_0000_0000, 40'hff_ffff_ffff, 40'hff_ffff_ffff, 1'b1, 1'b1},
            // End directly after an end: the count was cleared.
            '{40'h12_3456_789a, 40'h12_3456_789a, 40'h98_7654_3210, 1'b1, 1'b1},
            // Timestamp wrap, zero latency, top bits cut off, alternating patterns.
            '{40'h00_0000_0001, 40'hff_ffff_ffff, 40'h00_0000_0000, 1'b0, 1'b0},
            '{40'h00_0000_0002, 40'h55_5555_5555, 40'h55_5555_5555, 1'b0, 1'b0},
            '{40'h00_0000_0003, 40'h00_0000_0001, 40'h00_0000_0000, 1'b0, 1'b0},
            '{40'h00_0000_0004, 40'h00_0000_0000, 40'h01_0000_0000, 1'b0, 1'b0},
            '{40'haa_aaaa_aaaa, 40'h55_5555_5555, 40'haa_aaaa_aaaa, 1'b0, 1'b0},
            '{40'h55_5555_5555, 40'haa_aaaa_aaaa, 40'h55_5555_5555, 1'b0, 1'b0},
            // Fill the rest of the first row.
            '{40'h00_0000_0010, 40'h00_0000_1000, 40'h00_0000_1234, 1'b0, 1'b0},
            '{40'h00_0000_0011, 40'h10_0000_0000, 40'h10_0000_0400, 1'b0, 1'b0},
            '{40'h00_0000_0012, 40'h7f_ffff_ff00, 40'h80_0000_0100, 1'b0, 1'b0},
            '{40'h00_0000_0013, 40'h00_1234_0000, 40'h00_1234_abcd, 1'b0, 1'b0},
            '{40'h00_0000_0014, 40'h00_0000_0100, 40'h00_0000_00ff, 1'b0, 1'b0},
            '{40'h00_0000_0015, 40'h33_3333_3333, 40'hcc_cccc_cccc, 1'b0, 1'b0},
            '{40'h00_0000_0016, 40'h0f_0f0f_0f0f, 40'hf0_f0f0_f0f0, 1'b0, 1'b0},
            '{40'h00_0000_0017, 40'h00_8000_0000, 40'h01_0000_0000, 1'b0, 1'b0},
            '{40'h00_0000_0018, 40'h00_0000_0007, 40'h00_0000_0fff, 1'b0, 1'b0},
            '{40'h00_0000_0019, 40'h42_0000_0000, 40'h42_0001_0000, 1'b0, 1'b0},
            // One lane of a second row: the other lanes keep the first row's values.
            '{40'h00_0000_001a, 40'h00_0000_0020, 40'h00_0000_0077, 1'b0, 1'b0},
            '{40'h00_0000_001b, 40'h00_0000_0000, 40'h00_0000_0000, 1'b1, 1'b0},
            // After an end the lane register is clear again.
            '{40'h00_0000_001c, 40'h00_0000_0100, 40'h00_0000_0164, 1'b0, 1'b0},
            '{40'h00_0000_001d, 40'h00_0000_0000, 40'h00_0000_0000, 1'b1, 1'b0}
        };

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_N; i++)
            push_packet(directed[i]);

        // Random runs of packets, each closed by an end-of-test word.
        run_idx     = 0;
        short_total = 0;
        while (short_total < RANDOM_ITEMS)
        begin
            if (run_idx == 2)
                run_len = FULL_STORE;
            else if (run_idx == 5)
                run_len = FULL_STORE + $urandom_range(1, 3 * LANES);
            else
            begin
                case ($urandom_range(0, 9))
                    0:       run_len = 0;
                    1, 2:    run_len = LANES * $urandom_range(1, 4);
                    default: run_len = $urandom_range(1, 3 * LANES);
                endcase
                short_total += run_len + 1;
            end
            for (i = 0; i < run_len; i++)
                push_packet(random_packet(1'b0));
            push_packet(random_packet(1'b1));
            run_idx++;
        end
        pkt_valid <= 1'b0;

        // Wait out the remaining words, then give stray words time to show.
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
